### design/i2a_pkg.sv
// Shared types, constants and helper functions of the integer to ASCII converter.
package i2a_pkg;

    // Fixed field widths of the two channels.
    localparam int IN_VALUE_W  = 64;
    localparam int MODE_W      = 2;
    localparam int CHAR_W      = 8;

    // Default number width and queue depth between front and back.
    localparam int VALUE_W_DEF = 64;
    localparam int Q_DEPTH     = 2;

    // Format selectors. Any code with bit 1 set selects hexadecimal.
    localparam logic [MODE_W-1:0] MODE_UNSIGNED = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SIGNED   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_HEX      = 2'd2;

    // Character codes used outside the digit table.
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_X     = 8'h78;

    // Digit table, upper-case hex.
    localparam logic [CHAR_W-1:0] DIGIT_TABLE [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
    };

    // Classification that travels with each magnitude through the queue.
    typedef struct packed {
        logic is_hex;
        logic neg;
    } t_job_flags;

    // Sequencer states of the back end.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SIGN,
        ST_HEX_X,
        ST_SKIP,
        ST_EMIT
    } t_back_state;

    // Decimal digits needed for an unsigned number of the given width.
    function automatic int dec_digits(input int width);
        return (width * 30103) / 100000 + 1;
    endfunction

    // Hex digits needed for an unsigned number of the given width.
    function automatic int hex_digits(input int width);
        return (width + 3) / 4;
    endfunction

    // Digit register size: room for the longer of the two forms.
    function automatic int num_digits(input int width);
        return (dec_digits(width) > hex_digits(width)) ? dec_digits(width) : hex_digits(width);
    endfunction

    // ASCII code of one digit nibble.
    function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] nib);
        return DIGIT_TABLE[nib];
    endfunction

endpackage

### design/i2a_if.sv
// Stream interfaces of the number input and the character output channels.
interface i2a_in_if import i2a_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [IN_VALUE_W-1:0] value;
    logic [MODE_W-1:0]     mode;

    modport source (output valid, output value, output mode, input ready);
    modport sink   (input valid, input value, input mode, output ready);
endinterface

interface i2a_out_if import i2a_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;
    logic              last;

    modport source (output valid, output char_code, output last, input ready);
    modport sink   (input valid, input char_code, input last, output ready);
endinterface

### design/i2a_front.sv
// Front end: accepts numbers, decodes the mode and forms the magnitude.
module i2a_front import i2a_pkg::*; #(
    parameter int VALUE_WIDTH = VALUE_W_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    i2a_in_if.sink                 i_num,
    output logic                   o_job_valid,
    input  logic                   i_job_ready,
    output logic [VALUE_WIDTH-1:0] o_job_mag,
    output t_job_flags             o_job_flags
);

    logic                   r_vld;
    logic [VALUE_WIDTH-1:0] r_mag;
    t_job_flags             r_flags;

    logic [VALUE_WIDTH-1:0] v;
    logic                   neg;
    logic                   take;

    // Only the low bits count; a signed negative is negated modulo the width.
    assign v    = i_num.value[VALUE_WIDTH-1:0];
    assign neg  = (i_num.mode == MODE_SIGNED) && v[VALUE_WIDTH-1];
    assign take = i_num.valid && i_num.ready;

    // The stage takes a beat whenever it is empty or its content moves on.
    assign i_num.ready = !r_vld || i_job_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_num.ready) begin
            r_vld <= i_num.valid;
        end
        if (take) begin
            r_mag          <= neg ? ((~v) + {{(VALUE_WIDTH-1){1'b0}}, 1'b1}) : v;
            r_flags.is_hex <= i_num.mode[1];
            r_flags.neg    <= neg;
        end
    end

    assign o_job_valid = r_vld;
    assign o_job_mag   = r_mag;
    assign o_job_flags = r_flags;

endmodule

### design/i2a_queue.sv
// Short queue that decouples the front end from the back end.
module i2a_queue import i2a_pkg::*; #(
    parameter int DATA_W = VALUE_W_DEF + 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr_valid,
    output logic              o_wr_ready,
    input  logic [DATA_W-1:0] i_wr_data,
    output logic              o_rd_valid,
    input  logic              i_rd_ready,
    output logic [DATA_W-1:0] o_rd_data
);

    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    logic [DATA_W-1:0] r_mem [Q_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic              wr_en;
    logic              rd_en;

    assign o_wr_ready = (r_count != CNT_W'(Q_DEPTH));
    assign o_rd_valid = (r_count != '0);
    assign wr_en      = i_wr_valid && o_wr_ready;
    assign rd_en      = o_rd_valid && i_rd_ready;
    assign o_rd_data  = r_mem[r_rd_ptr];

    // Storage is written at the tail only.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    // Pointers wrap at the depth; the count tracks occupancy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (rd_en) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### design/i2a_back.sv
// Back end: binary to BCD conversion, leading zero skip and character output.
module i2a_back import i2a_pkg::*; #(
    parameter int VALUE_WIDTH = VALUE_W_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_job_valid,
    output logic                   o_job_ready,
    input  logic [VALUE_WIDTH-1:0] i_job_mag,
    input  t_job_flags             i_job_flags,
    i2a_out_if.source              o_text
);

    localparam int NDIG  = num_digits(VALUE_WIDTH);
    localparam int DIG_W = 4 * NDIG;
    localparam int PAD_W = DIG_W - VALUE_WIDTH;
    localparam int CNT_W = $clog2(NDIG + 1);
    localparam int BIT_W = $clog2(VALUE_WIDTH + 1);

    t_back_state            r_state, n_state;
    logic [DIG_W-1:0]       r_bcd, n_bcd;
    logic [VALUE_WIDTH-1:0] r_shift, n_shift;
    logic [BIT_W-1:0]       r_bit, n_bit;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic                   r_hex, n_hex;
    logic                   r_neg, n_neg;
    logic                   r_out_valid, n_out_valid;
    logic [CHAR_W-1:0]      r_char, n_char;
    logic                   r_last, n_last;

    logic                   out_free;
    logic [3:0]             top_dig;
    logic [DIG_W-1:0]       bcd_adj;

    // The output register may be loaded when empty or being drained.
    assign out_free = !r_out_valid || o_text.ready;
    assign top_dig  = r_bcd[DIG_W-1 -: 4];

    // Add three to every BCD digit of five or more before each shift.
    always_comb begin
        for (int d = 0; d < NDIG; d++) begin
            bcd_adj[4*d +: 4] = (r_bcd[4*d +: 4] >= 4'd5) ? r_bcd[4*d +: 4] + 4'd3
                                                          : r_bcd[4*d +: 4];
        end
    end

    // Sequencer: next state, datapath updates and output beat.
    always_comb begin
        n_state     = r_state;
        n_bcd       = r_bcd;
        n_shift     = r_shift;
        n_bit       = r_bit;
        n_cnt       = r_cnt;
        n_hex       = r_hex;
        n_neg       = r_neg;
        n_out_valid = o_text.ready ? 1'b0 : r_out_valid;
        n_char      = r_char;
        n_last      = r_last;
        o_job_ready = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                o_job_ready = 1'b1;
                if (i_job_valid) begin
                    n_hex   = i_job_flags.is_hex;
                    n_neg   = i_job_flags.neg;
                    n_shift = i_job_mag;
                    n_bit   = BIT_W'(VALUE_WIDTH);
                    n_cnt   = CNT_W'(NDIG);
                    if (i_job_flags.is_hex) begin
                        n_bcd   = {{PAD_W{1'b0}}, i_job_mag};
                        n_state = ST_SIGN;
                    end else begin
                        n_bcd   = '0;
                        n_state = ST_CONV;
                    end
                end
            end
            ST_CONV: begin
                n_bcd   = {bcd_adj[DIG_W-2:0], r_shift[VALUE_WIDTH-1]};
                n_shift = r_shift << 1;
                n_bit   = r_bit - 1'b1;
                if (r_bit == BIT_W'(1)) begin
                    n_state = r_neg ? ST_SIGN : ST_SKIP;
                end
            end
            ST_SIGN: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_char      = r_hex ? CH_ZERO : CH_MINUS;
                    n_last      = 1'b0;
                    n_state     = r_hex ? ST_HEX_X : ST_SKIP;
                end
            end
            ST_HEX_X: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_char      = CH_X;
                    n_last      = 1'b0;
                    n_state     = ST_SKIP;
                end
            end
            ST_SKIP: begin
                if (top_dig == 4'd0 && r_cnt != CNT_W'(1)) begin
                    n_bcd = {r_bcd[DIG_W-5:0], 4'd0};
                    n_cnt = r_cnt - 1'b1;
                end else begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_char      = digit_char(top_dig);
                    n_last      = (r_cnt == CNT_W'(1));
                    n_bcd       = {r_bcd[DIG_W-5:0], 4'd0};
                    n_cnt       = r_cnt - 1'b1;
                    if (r_cnt == CNT_W'(1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State and output valid are cleared by reset; the datapath is not.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_bcd   <= n_bcd;
        r_shift <= n_shift;
        r_bit   <= n_bit;
        r_cnt   <= n_cnt;
        r_hex   <= n_hex;
        r_neg   <= n_neg;
        r_char  <= n_char;
        r_last  <= n_last;
    end

    assign o_text.valid     = r_out_valid;
    assign o_text.char_code = r_char;
    assign o_text.last      = r_last;

endmodule

### design/integer_to_ascii_converter.sv
// Top level of the integer to ASCII converter: front end, queue and back end.
//
//  Channel  Dir  Payload                          Beat
//  i_num    in   value[63:0], mode[1:0]           one number
//  o_text   out  char_code[7:0], last             one character
//
// Each number leaves the queue into the back end, which then runs a serial
// shift-and-add-3 conversion over all VALUE_WIDTH bits in decimal modes,
// skips leading zero digits one at a time and sends one character per beat;
// in decimal modes the serial BCD converter in the back end does most of
// the work. Hex numbers skip the converter. The front end and the
// two-entry queue keep taking numbers while the back end works. A stalled
// output beat holds its character; the sequencer waits on it. Reset is
// synchronous and clears all control state.
module integer_to_ascii_converter import i2a_pkg::*; #(
    parameter int VALUE_WIDTH = VALUE_W_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    i2a_in_if.sink    i_num,
    i2a_out_if.source o_text
);

    localparam int JOB_W = VALUE_WIDTH + $bits(t_job_flags);

    logic                   fe_valid;
    logic                   fe_ready;
    logic [VALUE_WIDTH-1:0] fe_mag;
    t_job_flags             fe_flags;

    logic                   be_valid;
    logic                   be_ready;
    logic [JOB_W-1:0]       be_data;

    i2a_front #(.VALUE_WIDTH(VALUE_WIDTH)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_num       (i_num),
        .o_job_valid (fe_valid),
        .i_job_ready (fe_ready),
        .o_job_mag   (fe_mag),
        .o_job_flags (fe_flags)
    );

    i2a_queue #(.DATA_W(JOB_W)) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (fe_valid),
        .o_wr_ready (fe_ready),
        .i_wr_data  ({fe_flags, fe_mag}),
        .o_rd_valid (be_valid),
        .i_rd_ready (be_ready),
        .o_rd_data  (be_data)
    );

    i2a_back #(.VALUE_WIDTH(VALUE_WIDTH)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (be_valid),
        .o_job_ready (be_ready),
        .i_job_mag   (be_data[VALUE_WIDTH-1:0]),
        .i_job_flags (t_job_flags'(be_data[JOB_W-1:VALUE_WIDTH])),
        .o_text      (o_text)
    );

endmodule

### design/i2a_checker.sv
// Port-level checks of the converter output and their attachment to the top level.
module i2a_checker import i2a_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [CHAR_W-1:0] i_char_code,
    input logic              i_last
);

    // A stalled character beat holds until taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_char_code) && $stable(i_last))
        else $error("output beat changed while stalled");

    // Nothing is offered right after a reset cycle.
    a_reset_quiet: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !i_out_valid)
        else $error("output valid right after reset");

    // A sign or the hex prefix letter never ends a number.
    a_prefix_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_char_code == CH_MINUS || i_char_code == CH_X) |-> !i_last)
        else $error("prefix character marked last");

    // The final character of a number is always a digit.
    a_last_is_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_last |->
            (i_char_code >= 8'h30 && i_char_code <= 8'h39) ||
            (i_char_code >= 8'h41 && i_char_code <= 8'h46))
        else $error("last character is not a digit");

endmodule

bind integer_to_ascii_converter i2a_checker u_i2a_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_text.valid),
    .i_out_ready (o_text.ready),
    .i_char_code (o_text.char_code),
    .i_last      (o_text.last)
);

### bench/tb_i2a_checker.sv
// Checker that predicts the text of every accepted number and compares each output beat.
`timescale 1ns / 1ps

module tb_i2a_checker import i2a_pkg::*; #(
    parameter int VALUE_WIDTH = VALUE_W_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    i2a_in_if    i_num,
    i2a_out_if   i_text,
    output int   o_fail_count,
    output int   o_pending
);

    localparam int MAX_TEXT = 20;

    // Characters the formatter writes besides decimal digits.
    localparam logic [CHAR_W-1:0] ASCII_ZERO    = "0";
    localparam logic [CHAR_W-1:0] ASCII_UPPER_A = "A";
    localparam logic [CHAR_W-1:0] ASCII_MINUS   = "-";
    localparam logic [CHAR_W-1:0] ASCII_X       = "x";

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
    } t_char_beat;

    t_char_beat expected_chars[$];
    int         fail_total    = 0;
    int         pending_chars = 0;

    assign o_fail_count = fail_total;
    assign o_pending    = pending_chars;

    // Formats one number the way the block should and queues its characters.
    function automatic void predict_text(input logic [IN_VALUE_W-1:0] raw,
                                         input logic [MODE_W-1:0]     mode);
        logic [IN_VALUE_W-1:0] mask;
        logic [IN_VALUE_W-1:0] num;
        logic [IN_VALUE_W-1:0] mag;
        logic [IN_VALUE_W-1:0] radix;
        logic [3:0]            digit;
        logic [CHAR_W-1:0]     text [MAX_TEXT + 2];
        logic [CHAR_W-1:0]     rev  [MAX_TEXT];
        t_char_beat            beat;
        int                    len;
        int                    n;
        int                    k;
        mask = '1;
        mask = mask >> (IN_VALUE_W - VALUE_WIDTH);
        num  = raw & mask;
        len  = 0;
        // Any selector with the hex bit set is hexadecimal, the undefined code too.
        if ((mode & MODE_HEX) != '0) begin
            text[0] = ASCII_ZERO;
            text[1] = ASCII_X;
            len     = 2;
            radix   = 64'd16;
            mag     = num;
        end else if (mode == MODE_SIGNED && num[VALUE_WIDTH-1]) begin
            // The magnitude wraps at the width, so the most negative value prints exactly.
            text[0] = ASCII_MINUS;
            len     = 1;
            radix   = 64'd10;
            mag     = (~num + 1'b1) & mask;
        end else begin
            radix = 64'd10;
            mag   = num;
        end
        // Digits come out least significant first.
        n = 0;
        do begin
            digit  = 4'(mag % radix);
            rev[n] = (digit < 4'd10) ? ASCII_ZERO + CHAR_W'(digit)
                                     : ASCII_UPPER_A + CHAR_W'(digit) - CHAR_W'(10);
            mag    = mag / radix;
            n++;
        end while (mag != '0 && n < MAX_TEXT);
        for (k = n - 1; k >= 0; k--) begin
            text[len] = rev[k];
            len++;
        end
        for (k = 0; k < len; k++) begin
            beat.code = text[k];
            beat.last = (k == len - 1);
            expected_chars.push_back(beat);
        end
    endfunction

    // Check output beats against the oldest prediction, then predict new numbers.
    always @(posedge i_clk) begin : watch
        t_char_beat want;
        logic       bad;
        bad = 1'b0;
        if (i_rst_n && i_text.valid && i_text.ready) begin
            if (expected_chars.size() == 0) begin
                $display("%0t: unexpected character beat, expected none, actual %h last %b",
                         $time, i_text.char_code, i_text.last);
                bad = 1'b1;
            end else begin
                want = expected_chars.pop_front();
                if (i_text.char_code !== want.code) begin
                    $display("%0t: char_code mismatch, expected %h actual %h",
                             $time, want.code, i_text.char_code);
                    bad = 1'b1;
                end
                if (i_text.last !== want.last) begin
                    $display("%0t: last mismatch, expected %b actual %b",
                             $time, want.last, i_text.last);
                    bad = 1'b1;
                end
            end
        end
        if (i_rst_n && i_num.valid && i_num.ready) begin
            predict_text(i_num.value, i_num.mode);
        end
        if (bad) begin
            fail_total <= fail_total + 1;
        end
        pending_chars <= expected_chars.size();
    end

endmodule

### bench/tb_integer_to_ascii_converter.sv
// Top of the converter testbench: clock, reset, number stimulus, output stalls and verdict.
`timescale 1ns / 1ps

module tb_integer_to_ascii_converter;
    import i2a_pkg::*;

    localparam int RANDOM_ITEMS = 410;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int LONG_HOLD    = 400;
    localparam int DRAIN_CYCLES = 200;
    localparam int MAX_IDLE     = 19;

    // Selector with no defined meaning; the block treats it as hexadecimal.
    localparam logic [MODE_W-1:0] MODE_UNDEF = MODE_HEX | MODE_SIGNED;

    logic        i_clk   = 1'b0;
    logic        i_rst_n;
    int unsigned cycle_count   = 0;
    int          fail_count;
    int          pending;
    logic        sender_calm   = 1'b0;
    logic        receiver_calm = 1'b0;
    int          hold_requests = 0;

    i2a_in_if  num_if ();
    i2a_out_if text_if ();

    integer_to_ascii_converter #(
        .VALUE_WIDTH(VALUE_W_DEF)
    ) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_num  (num_if),
        .o_text (text_if)
    );

    tb_i2a_checker #(
        .VALUE_WIDTH(VALUE_W_DEF)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_num       (num_if),
        .i_text      (text_if),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    // 12 ns clock.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // Watchdog for a hung run.
    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge i_clk);
        $display("tb: failure");
        $finish;
    end

    // Offers one number beat after a random gap, none while the sender is calm, and returns once it is accepted.
    task automatic send_number(input logic [IN_VALUE_W-1:0] value,
                               input logic [MODE_W-1:0]     mode);
        int gap;
        gap = sender_calm ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap > 0) begin
            num_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        num_if.valid <= 1'b1;
        num_if.value <= value;
        num_if.mode  <= mode;
        @(posedge i_clk);
        while (!num_if.ready) @(posedge i_clk);
    endtask

    // Random numbers weighted toward short lengths, digit-count boundaries and sign edges.
    function automatic logic [IN_VALUE_W-1:0] random_number();
        logic [IN_VALUE_W-1:0] v;
        logic [IN_VALUE_W-1:0] p;
        int                    bits;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0, 1, 2: begin
            end
            3, 4, 5: begin
                bits = $urandom_range(1, 63);
                v    = v & ((64'd1 << bits) - 64'd1);
            end
            6: begin
                v = 64'($urandom_range(0, 99));
            end
            7: begin
                p = 64'd1;
                repeat ($urandom_range(0, 19)) p = p * 64'd10;
                v = p - 64'd1 + 64'($urandom_range(0, 2));
            end
            8: begin
                v = $urandom_range(0, 1) ? 64'h8000_0000_0000_0000 + 64'($urandom_range(0, 3))
                                         : ~64'($urandom_range(0, 3));
            end
            default: begin
                v = 64'h7FFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 3));
            end
        endcase
        return v;
    endfunction

    // Receiver: random stall before each character beat, plus long hold-offs on request.
    initial begin : receiver
        int stall;
        int holds_done;
        holds_done = 0;
        text_if.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = receiver_calm ? 0 : $urandom_range(0, MAX_IDLE);
            if (holds_done < hold_requests) begin
                stall = stall + LONG_HOLD;
                holds_done++;
            end
            if (stall > 0) begin
                text_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            text_if.ready <= 1'b1;
            @(posedge i_clk);
            while (!text_if.valid) @(posedge i_clk);
        end
    end

    // Stimulus: directed corner numbers, then random numbers in several phases.
    initial begin : stimulus
        logic [MODE_W-1:0] mode;
        num_if.valid <= 1'b0;
        num_if.value <= '0;
        num_if.mode  <= MODE_UNSIGNED;
        i_rst_n      <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Zero in every mode, all ones, the sign boundary and digit-count boundaries.
        send_number(64'd0, MODE_UNSIGNED);
        send_number(64'd0, MODE_SIGNED);
        send_number(64'd0, MODE_HEX);
        send_number(64'd0, MODE_UNDEF);
        send_number(64'hFFFF_FFFF_FFFF_FFFF, MODE_UNSIGNED);
        send_number(64'hFFFF_FFFF_FFFF_FFFF, MODE_SIGNED);
        send_number(64'hFFFF_FFFF_FFFF_FFFF, MODE_HEX);
        send_number(64'hFFFF_FFFF_FFFF_FFFF, MODE_UNDEF);
        send_number(64'h8000_0000_0000_0000, MODE_SIGNED);
        send_number(64'h8000_0000_0000_0000, MODE_UNSIGNED);
        send_number(64'h8000_0000_0000_0000, MODE_HEX);
        send_number(64'h7FFF_FFFF_FFFF_FFFF, MODE_SIGNED);
        send_number(64'd1, MODE_UNSIGNED);
        send_number(64'd9, MODE_SIGNED);
        send_number(64'd10, MODE_UNSIGNED);
        send_number(64'd99, MODE_UNSIGNED);
        send_number(64'd100, MODE_SIGNED);
        send_number(64'd9999999999999999999, MODE_UNSIGNED);
        send_number(64'd10000000000000000000, MODE_UNSIGNED);
        send_number(-64'sd10, MODE_SIGNED);
        send_number(64'h0123_4567_89AB_CDEF, MODE_HEX);
        send_number(64'hFEDC_BA98_7654_3210, MODE_UNDEF);
        send_number(64'hF, MODE_HEX);
        send_number(64'h10, MODE_HEX);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            // Let the block drain completely once before going on.
            if (i == 150) begin
                num_if.valid <= 1'b0;
                @(posedge i_clk);
                while (pending != 0) @(posedge i_clk);
            end
            // A stretch with no idling on either side.
            if (i == 200) begin
                sender_calm   = 1'b1;
                receiver_calm = 1'b1;
            end
            if (i == 240) begin
                sender_calm   = 1'b0;
                receiver_calm = 1'b0;
            end
            // Long receiver hold-off while numbers keep coming back to back.
            if (i == 300) begin
                hold_requests = hold_requests + 1;
                sender_calm   = 1'b1;
            end
            if (i == 340) begin
                sender_calm = 1'b0;
            end
            mode = MODE_W'($urandom_range(0, 3));
            send_number(random_number(), mode);
        end
        num_if.valid <= 1'b0;

        // Wait for every predicted character, then a little longer for strays.
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

### filelist.f
design/i2a_pkg.sv
design/i2a_if.sv
design/i2a_front.sv
design/i2a_queue.sv
design/i2a_back.sv
design/integer_to_ascii_converter.sv
design/i2a_checker.sv
bench/tb_i2a_checker.sv
bench/tb_integer_to_ascii_converter.sv
